// File: rtl/m3inv_pkg.sv
// Shared widths, types and helpers for the 3x3 adjugate matrix inverter.
// No dependencies; used by every other file of the block.
package m3inv_pkg;

  localparam int NUM_EL  = 9;
  localparam int IN_W    = 16;                  // Q8.8 entry
  localparam int OUT_W   = 32;                  // Q16.16 result
  localparam int PROD_W  = 2 * IN_W;            // 2x2 minor product
  localparam int COF_W   = PROD_W + 1;          // signed cofactor
  localparam int DET_W   = IN_W + COF_W + 2;    // sum of three terms, with margin
  localparam int DMAG_W  = DET_W - 1;           // determinant magnitude
  localparam int AMAG_W  = COF_W - 1;           // adjugate magnitude
  localparam int FRAC_SH = 24;                  // numerator pre-shift
  localparam int NUM_W   = AMAG_W + FRAC_SH;    // numerator width
  localparam int QB      = OUT_W;               // quotient bits resolved by steps
  localparam int HI_W    = NUM_W - QB;          // numerator bits above the quotient
  localparam int REM_W   = DMAG_W + 1;          // partial remainder
  localparam int PASS_SH = 8;                   // Q8.8 -> Q16.16
  localparam int FRONT_ST = 5;
  localparam int LANE_ST  = QB + 2;
  localparam int PIPE_D   = FRONT_ST + LANE_ST;

  typedef logic signed [IN_W-1:0]  elem_t;
  typedef logic signed [OUT_W-1:0] res_t;

  // per-lane word handed from the cofactor front end to a divider lane
  typedef struct packed {
    logic [AMAG_W-1:0] adj_mag;
    logic              neg;
    logic              sing;
    elem_t             pass;
  } lane_in_t;

  typedef struct packed {
    logic [NUM_EL-1:0][OUT_W-1:0] inv;
    logic                         singular;
  } result_t;

  // lower and upper of the two rows (or columns) other than idx
  function automatic int unsigned other_lo(input int unsigned idx);
    return (idx == 0) ? 1 : 0;
  endfunction

  function automatic int unsigned other_hi(input int unsigned idx);
    return (idx == 2) ? 1 : 2;
  endfunction

endpackage

// File: rtl/m3inv_if.sv
// Valid/ready channel interfaces for the matrix inverter.
// Depends on m3inv_pkg.
interface m3inv_in_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::IN_W-1:0] elem_r0c0, elem_r0c1, elem_r0c2;
  logic signed [m3inv_pkg::IN_W-1:0] elem_r1c0, elem_r1c1, elem_r1c2;
  logic signed [m3inv_pkg::IN_W-1:0] elem_r2c0, elem_r2c1, elem_r2c2;

  modport source (output valid, output elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0,
                  elem_r1c1, elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, input ready);
  modport sink (input valid, input elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0,
                elem_r1c1, elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, output ready);
endinterface

interface m3inv_out_if;
  logic valid;
  logic ready;
  logic signed [m3inv_pkg::OUT_W-1:0] inv_r0c0, inv_r0c1, inv_r0c2;
  logic signed [m3inv_pkg::OUT_W-1:0] inv_r1c0, inv_r1c1, inv_r1c2;
  logic signed [m3inv_pkg::OUT_W-1:0] inv_r2c0, inv_r2c1, inv_r2c2;
  logic singular;

  modport source (output valid, output inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0,
                  inv_r1c1, inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular,
                  input ready);
  modport sink (input valid, input inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0,
                inv_r1c1, inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, singular,
                output ready);
endinterface

// File: rtl/m3inv_front.sv
// Front end: minor products, signed cofactors, determinant, lane words.
// Five register stages, all advancing on en_i. Depends on m3inv_pkg.
module m3inv_front (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  m3inv_pkg::elem_t                elem_i [m3inv_pkg::NUM_EL],
  output m3inv_pkg::lane_in_t             lane_o [m3inv_pkg::NUM_EL],
  output logic [m3inv_pkg::DMAG_W-1:0]    det_mag_o
);
  import m3inv_pkg::*;

  elem_t                    m1_q [NUM_EL];
  elem_t                    m2_q [NUM_EL];
  elem_t                    m3_q [NUM_EL];
  elem_t                    m4_q [NUM_EL];
  logic signed [PROD_W-1:0] p_d  [2*NUM_EL];
  logic signed [PROD_W-1:0] p_q  [2*NUM_EL];
  logic signed [COF_W-1:0]  c_d  [NUM_EL];
  logic signed [COF_W-1:0]  c3_q [NUM_EL];
  logic signed [COF_W-1:0]  c4_q [NUM_EL];
  logic signed [IN_W+COF_W-1:0] t_d [3];
  logic signed [DET_W-1:0]  t_q  [3];
  logic signed [DET_W-1:0]  det;
  logic signed [COF_W-1:0]  adj  [NUM_EL];

  // two cross products per 2x2 minor
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        p_d[2*(r*3+k)]   = m1_q[other_lo(r)*3+other_lo(k)] * m1_q[other_hi(r)*3+other_hi(k)];
        p_d[2*(r*3+k)+1] = m1_q[other_lo(r)*3+other_hi(k)] * m1_q[other_hi(r)*3+other_lo(k)];
      end
    end
  end

  // minor difference with checkerboard sign
  always_comb begin
    for (int i = 0; i < NUM_EL; i++) begin
      c_d[i] = COF_W'(p_q[2*i]) - COF_W'(p_q[2*i+1]);
      if (i % 2 == 1) c_d[i] = -c_d[i];
    end
  end

  // first-row expansion terms
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_d[k] = m3_q[k] * c3_q[k];
    end
  end

  assign det = t_q[0] + t_q[1] + t_q[2];

  // adjugate is the transposed cofactor matrix
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        adj[r*3+k] = c4_q[k*3+r];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_EL; i++) begin
        m1_q[i] <= elem_i[i];
        m2_q[i] <= m1_q[i];
        m3_q[i] <= m2_q[i];
        m4_q[i] <= m3_q[i];
        c3_q[i] <= c_d[i];
        c4_q[i] <= c3_q[i];
        lane_o[i].adj_mag <= adj[i][COF_W-1] ? AMAG_W'(-adj[i]) : AMAG_W'(adj[i]);
        lane_o[i].neg     <= adj[i][COF_W-1] ^ det[DET_W-1];
        lane_o[i].sing    <= (det == '0);
        lane_o[i].pass    <= m4_q[i];
      end
      for (int j = 0; j < 2*NUM_EL; j++) begin
        p_q[j] <= p_d[j];
      end
      for (int k = 0; k < 3; k++) begin
        t_q[k] <= DET_W'(t_d[k]);
      end
      det_mag_o <= det[DET_W-1] ? DMAG_W'(-det) : DMAG_W'(det);
    end
  end

endmodule

// File: rtl/m3inv_lane.sv
// Divider lane: (|adj| << 24) / |det| by restoring long division, one
// quotient bit per stage, then sign, saturation and singular bypass.
// Depends on m3inv_pkg.
module m3inv_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  m3inv_pkg::lane_in_t           lane_i,
  input  logic [m3inv_pkg::DMAG_W-1:0]  det_mag_i,
  output logic [m3inv_pkg::OUT_W-1:0]   res_o,
  output logic                          sing_o
);
  import m3inv_pkg::*;

  logic [REM_W-1:0]  rem_q  [QB+1];
  logic [DMAG_W-1:0] dv_q   [QB+1];
  logic [QB-1:0]     nb_q   [QB+1];
  logic [QB-1:0]     quo_q  [QB+1];
  logic              ovf_q  [QB+1];
  logic              neg_q  [QB+1];
  logic              sing_q [QB+1];
  elem_t             pass_q [QB+1];
  logic [NUM_W-1:0]  num;
  logic [QB-1:0]     quo;
  logic [QB-1:0]     res_d;
  localparam logic [QB-1:0] MAX_POS = {1'b0, {(QB-1){1'b1}}};
  localparam logic [QB-1:0] MIN_MAG = {1'b1, {(QB-1){1'b0}}};

  assign num = {lane_i.adj_mag, FRAC_SH'(0)};

  // setup: quotient overflows when the high numerator part reaches |det|
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= REM_W'(num[NUM_W-1:QB]);
      ovf_q[0]  <= REM_W'(num[NUM_W-1:QB]) >= REM_W'(det_mag_i);
      nb_q[0]   <= num[QB-1:0];
      quo_q[0]  <= '0;
      dv_q[0]   <= det_mag_i;
      neg_q[0]  <= lane_i.neg;
      sing_q[0] <= lane_i.sing;
      pass_q[0] <= lane_i.pass;
    end
  end

  // one quotient bit per stage
  for (genvar s = 1; s <= QB; s++) begin : g_step
    logic [REM_W:0] trial;
    logic           ge;
    assign trial = {rem_q[s-1], nb_q[s-1][QB-1]};
    assign ge    = trial >= {1'b0, 1'b0, dv_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= ge ? REM_W'(trial - {1'b0, 1'b0, dv_q[s-1]}) : REM_W'(trial);
        nb_q[s]   <= {nb_q[s-1][QB-2:0], 1'b0};
        quo_q[s]  <= {quo_q[s-1][QB-2:0], ge};
        dv_q[s]   <= dv_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        sing_q[s] <= sing_q[s-1];
        pass_q[s] <= pass_q[s-1];
      end
    end
  end

  assign quo = quo_q[QB];

  // sign, saturation, singular bypass
  always_comb begin
    if (sing_q[QB]) begin
      res_d = OUT_W'(pass_q[QB]) << PASS_SH;
    end else if (neg_q[QB]) begin
      res_d = (ovf_q[QB] || quo > MIN_MAG) ? MIN_MAG : -quo;
    end else begin
      res_d = (ovf_q[QB] || quo > MAX_POS) ? MAX_POS : quo;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o  <= res_d;
      sing_o <= sing_q[QB];
    end
  end

endmodule

// File: rtl/m3inv_outbuf.sv
// Merge stage: gathers the nine lane results into one word and holds it in
// a two-entry output buffer (head plus skid). Depends on m3inv_pkg.
module m3inv_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [m3inv_pkg::OUT_W-1:0] lane_res_i [m3inv_pkg::NUM_EL],
  input  logic                  sing_i,
  input  logic                  ready_i,
  output logic                  valid_o,
  output m3inv_pkg::result_t    data_o,
  output logic                  en_o
);
  import m3inv_pkg::*;

  result_t word;
  result_t head_q, skid_q;
  logic    head_vld_q, skid_vld_q;
  logic    pop;

  always_comb begin
    for (int i = 0; i < NUM_EL; i++) begin
      word.inv[i] = lane_res_i[i];
    end
    word.singular = sing_i;
  end

  assign pop     = head_vld_q && ready_i;
  assign en_o    = !skid_vld_q || ready_i;
  assign valid_o = head_vld_q;
  assign data_o  = head_q;

  // buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_vld_q) begin
          skid_vld_q <= push_i;
        end else begin
          head_vld_q <= push_i;
        end
      end else if (push_i) begin
        if (head_vld_q) skid_vld_q <= 1'b1;
        else            head_vld_q <= 1'b1;
      end
    end
  end

  // buffer data
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_vld_q) begin
        head_q <= skid_q;
        if (push_i) skid_q <= word;
      end else if (push_i) begin
        head_q <= word;
      end
    end else if (push_i) begin
      if (head_vld_q) skid_q <= word;
      else            head_q <= word;
    end
  end

  a_skid_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> head_vld_q)
    else $error("skid entry valid without head entry");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && skid_vld_q) |-> ready_i)
    else $error("word pushed into a full output buffer");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_vld_q) |-> $past(head_vld_q && !ready_i))
    else $error("skid filled although head was free");

endmodule

// File: rtl/matrix3_inverse.sv
// 3x3 matrix inverse by adjugate: Q8.8 in, saturated Q16.16 out.
// Each accepted matrix passes the front end, the divider lanes and the output buffer.
// Throughput: one matrix per cycle; nine divider lanes, one quotient bit per stage.
// Stalls only when the two-entry output buffer is full and output not ready.
// Reset (rst_ni, async active low) clears the valid pipeline and output buffer.
// Depends on m3inv_pkg, m3inv_if, m3inv_front, m3inv_lane, m3inv_outbuf.
module matrix3_inverse (
  input  logic        clk_i,
  input  logic        rst_ni,
  m3inv_in_if.sink    in_i,
  m3inv_out_if.source out_o
);
  import m3inv_pkg::*;

  logic              en;
  logic [PIPE_D-1:0] vld_q;
  elem_t             elem [NUM_EL];
  lane_in_t          lane_in [NUM_EL];
  logic [DMAG_W-1:0] det_mag;
  logic [OUT_W-1:0]  lane_res [NUM_EL];
  logic              lane_sing [NUM_EL];
  result_t           data;

  assign in_i.ready = en;

  assign elem[0] = in_i.elem_r0c0;
  assign elem[1] = in_i.elem_r0c1;
  assign elem[2] = in_i.elem_r0c2;
  assign elem[3] = in_i.elem_r1c0;
  assign elem[4] = in_i.elem_r1c1;
  assign elem[5] = in_i.elem_r1c2;
  assign elem[6] = in_i.elem_r2c0;
  assign elem[7] = in_i.elem_r2c1;
  assign elem[8] = in_i.elem_r2c2;

  // valid tracking along the whole datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_D-2:0], in_i.valid};
    end
  end

  m3inv_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .elem_i    (elem),
    .lane_o    (lane_in),
    .det_mag_o (det_mag)
  );

  for (genvar i = 0; i < NUM_EL; i++) begin : g_lane
    m3inv_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .lane_i    (lane_in[i]),
      .det_mag_i (det_mag),
      .res_o     (lane_res[i]),
      .sing_o    (lane_sing[i])
    );
  end

  m3inv_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (en && vld_q[PIPE_D-1]),
    .lane_res_i (lane_res),
    .sing_i     (lane_sing[0]),
    .ready_i    (out_o.ready),
    .valid_o    (out_o.valid),
    .data_o     (data),
    .en_o       (en)
  );

  assign out_o.inv_r0c0 = data.inv[0];
  assign out_o.inv_r0c1 = data.inv[1];
  assign out_o.inv_r0c2 = data.inv[2];
  assign out_o.inv_r1c0 = data.inv[3];
  assign out_o.inv_r1c1 = data.inv[4];
  assign out_o.inv_r1c2 = data.inv[5];
  assign out_o.inv_r2c0 = data.inv[6];
  assign out_o.inv_r2c1 = data.inv[7];
  assign out_o.inv_r2c2 = data.inv[8];
  assign out_o.singular = data.singular;

endmodule

// File: verif/matrix3_inverse_chk.sv
// Checker for the 3x3 matrix inverter: watches both channels, computes the expected
// inverse of each accepted matrix and compares it with each delivered result.
// Depends on m3inv_pkg and m3inv_if.
module matrix3_inverse_chk (
  input  logic clk_i,
  input  logic rst_ni,
  m3inv_in_if  in_mon,
  m3inv_out_if out_mon,
  output int   fail_cnt_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import m3inv_pkg::*;

  typedef struct {
    logic signed [OUT_W-1:0] inv [9];
    logic                    singular;
  } inv_word_t;

  inv_word_t inv_fifo[$];
  int        fail_cnt;

  assign fail_cnt_o = fail_cnt;

  // (adj << 24) / det, truncated toward zero and saturated to OUT_W bits
  function automatic logic signed [OUT_W-1:0] div_sat(longint adj, longint det);
    logic [127:0] num, q;
    logic [63:0]  dmag;
    bit           neg;
    neg  = (adj < 0) != (det < 0);
    num  = 128'(adj < 0 ? -adj : adj) << FRAC_SH;
    dmag = det < 0 ? -det : det;
    q    = num / dmag;
    if (neg) begin
      if (q > 128'h8000_0000) q = 128'h8000_0000;
      return OUT_W'(-q);
    end
    if (q > 128'h7fff_ffff) q = 128'h7fff_ffff;
    return OUT_W'(q);
  endfunction

  function automatic inv_word_t invert3(longint m[3][3]);
    longint    cof[3][3];
    longint    det;
    inv_word_t w;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        cof[r][k] = m[(r == 0) ? 1 : 0][(k == 0) ? 1 : 0] * m[(r == 2) ? 1 : 2][(k == 2) ? 1 : 2]
                  - m[(r == 0) ? 1 : 0][(k == 2) ? 1 : 2] * m[(r == 2) ? 1 : 2][(k == 0) ? 1 : 0];
        if ((r + k) % 2) cof[r][k] = -cof[r][k];
      end
    end
    det = m[0][0] * cof[0][0] + m[0][1] * cof[0][1] + m[0][2] * cof[0][2];
    w.singular = (det == 0);
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        if (w.singular) w.inv[r*3+k] = OUT_W'(m[r][k] << PASS_SH);
        else w.inv[r*3+k] = div_sat(cof[k][r], det);
      end
    end
    return w;
  endfunction

  // predict on input words, compare on output words
  always @(posedge clk_i) begin
    longint    m[3][3];
    inv_word_t got, want;
    if (rst_ni && in_mon.valid && in_mon.ready) begin
      m[0][0] = in_mon.elem_r0c0; m[0][1] = in_mon.elem_r0c1; m[0][2] = in_mon.elem_r0c2;
      m[1][0] = in_mon.elem_r1c0; m[1][1] = in_mon.elem_r1c1; m[1][2] = in_mon.elem_r1c2;
      m[2][0] = in_mon.elem_r2c0; m[2][1] = in_mon.elem_r2c1; m[2][2] = in_mon.elem_r2c2;
      inv_fifo.push_back(invert3(m));
    end
    if (rst_ni && out_mon.valid && out_mon.ready) begin
      got.inv = '{out_mon.inv_r0c0, out_mon.inv_r0c1, out_mon.inv_r0c2,
                  out_mon.inv_r1c0, out_mon.inv_r1c1, out_mon.inv_r1c2,
                  out_mon.inv_r2c0, out_mon.inv_r2c1, out_mon.inv_r2c2};
      got.singular = out_mon.singular;
      if (inv_fifo.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result word at %0t", $realtime);
      end else begin
        want = inv_fifo.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got.inv[i] !== want.inv[i]) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("inv r%0dc%0d: expected %0d got %0d", i / 3, i % 3,
                       want.inv[i], got.inv[i]);
          end
        end
        if (got.singular !== want.singular) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("singular: expected %0b got %0b", want.singular, got.singular);
        end
      end
    end
    pending_o = inv_fifo.size();
  end
endmodule

// File: verif/matrix3_inverse_tb.sv
// Testbench top for matrix3_inverse: drives matrices with random idling and a long
// output hold-off, and reports the verdict. Depends on m3inv_pkg, m3inv_if and the checker.
module matrix3_inverse_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import m3inv_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_cnt, pending;
  int   send_idle_pct = 9, recv_idle_pct = 79;
  bit   hold_off = 1'b0;
  bit   rdy_rand = 1'b0;

  m3inv_in_if  in_ch();
  m3inv_out_if out_ch();

  matrix3_inverse u_top (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink),
                         .out_o(out_ch.source));
  matrix3_inverse_chk u_chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_mon(in_ch),
                             .out_mon(out_ch), .fail_cnt_o(fail_cnt), .pending_o(pending));

  always #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("[matrix3_inverse] ERROR");
    $finish;
  end

  // receiver: random stalls, plus a hold-off window
  initial out_ch.ready = 1'b0;
  always @(posedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.elem_r0c0, in_ch.elem_r0c1, in_ch.elem_r0c2, in_ch.elem_r1c0, in_ch.elem_r1c1,
     in_ch.elem_r1c2, in_ch.elem_r2c0, in_ch.elem_r2c1, in_ch.elem_r2c2} = '0;
  end

  // offer one matrix, with a random idle gap first; returns once accepted
  task automatic send_matrix(input elem_t e[9]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.elem_r0c0, in_ch.elem_r0c1, in_ch.elem_r0c2, in_ch.elem_r1c0, in_ch.elem_r1c1,
     in_ch.elem_r1c2, in_ch.elem_r2c0, in_ch.elem_r2c1, in_ch.elem_r2c2}
      <= {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  function automatic elem_t rand_entry();
    case ($urandom_range(5))
      0: return elem_t'($urandom);
      1: return elem_t'($signed($urandom_range(1024)) - 512);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      3: return elem_t'($signed($urandom_range(8)) - 4) <<< 8;
      default: return elem_t'($signed($urandom_range(16)) - 8);
    endcase
  endfunction

  task automatic send_random(input int n);
    elem_t e[9];
    for (int i = 0; i < n; i++) begin
      foreach (e[j]) e[j] = rand_entry();
      // some singular matrices: duplicate or zero a row
      case ($urandom_range(7))
        0: begin
          e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
        end
        1: begin
          e[3] = 0; e[4] = 0; e[5] = 0;
        end
        default: ;
      endcase
      send_matrix(e);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    elem_t e[9];
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: identity, scaled, all zero, extremes, near-singular, saturation
    e = '{16'sh0100, 0, 0, 0, 16'sh0100, 0, 0, 0, 16'sh0100}; send_matrix(e);
    e = '{16'sh0200, 0, 0, 0, -16'sh0400, 0, 0, 0, 16'sh0080}; send_matrix(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(e);
    e = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh7fff, 16'sh7fff}; send_matrix(e);
    e = '{16'sh8000, 0, 0, 0, 16'sh8000, 0, 0, 0, 16'sh8000}; send_matrix(e);
    e = '{16'sh7fff, 0, 0, 0, 16'sh7fff, 0, 0, 0, 16'sh7fff}; send_matrix(e);
    e = '{1, 0, 0, 0, 1, 0, 0, 0, 1}; send_matrix(e);
    e = '{-1, 0, 0, 0, 1, 0, 0, 0, -1}; send_matrix(e);
    e = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh8000, 16'sh7fff}; send_matrix(e);
    e = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; send_matrix(e);
    e = '{1, 2, 3, 4, 5, 6, 7, 8, 10}; send_matrix(e);
    e = '{16'sh7fff, 1, 0, 1, 1, 0, 0, 0, 1}; send_matrix(e);
    e = '{-16'sh5555, 16'sh2aaa, -1, 16'sh0001, 16'sh8000, 16'sh0fff, 2, -3, 16'sh7ffe};
    send_matrix(e);
    e = '{0, 16'sh0100, 0, 0, 0, 16'sh0100, 16'sh0100, 0, 0}; send_matrix(e);
    in_ch.valid <= 1'b0;

    send_random(400);
    send_idle_pct = 79; recv_idle_pct = 9;
    send_random(400);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(50);

    // long output hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk_i);
        hold_off = 1'b0;
      end
      send_random(100);
    join
    send_random(300);

    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) $display("[matrix3_inverse] OK");
    else $display("[matrix3_inverse] ERROR");
    $finish;
  end
endmodule
